FILE: rtl/core/hkf_pkg.sv
// package: shared types, constants and helpers of the hotkey filter
`timescale 1ns / 1ps
package hkf_pkg;

  localparam int RING_DEPTH_DEF = 64;
  localparam int SLOT_COUNT_DEF = 16;
  localparam int KEY_COUNT      = 6;
  localparam int CODE_W         = 8;
  localparam int REPORT_W       = CODE_W * (KEY_COUNT + 1);
  localparam int OWNER_W        = 16;
  localparam int SLOT_NUM_W     = 4;
  localparam int TABLE_W        = REPORT_W + OWNER_W;

  typedef enum logic [1:0] {
    CMD_KEYPRESS  = 2'd0,
    CMD_READ      = 2'd1,
    CMD_SUBSCRIBE = 2'd2,
    CMD_QUERY     = 2'd3
  } cmd_t;

  typedef enum logic [2:0] {
    ST_OK       = 3'd0,
    ST_ABSORBED = 3'd1,
    ST_NOFOCUS  = 3'd2,
    ST_EMPTY    = 3'd3,
    ST_FULL     = 3'd4
  } status_t;

  typedef enum logic [0:0] {
    CFG_SHORTCUT_BYPASS = 1'b0,
    CFG_FOCUS_VALID     = 1'b1
  } cfg_idx_t;

  typedef enum logic [2:0] {
    S_IDLE,
    S_SCAN,
    S_ENQUEUE,
    S_POP_WAIT,
    S_QUERY_WAIT,
    S_RESULT
  } state_t;

  typedef struct packed {
    logic [CODE_W-1:0] modifier;
    logic [CODE_W-1:0] code0;
    logic [CODE_W-1:0] code1;
    logic [CODE_W-1:0] code2;
    logic [CODE_W-1:0] code3;
    logic [CODE_W-1:0] code4;
    logic [CODE_W-1:0] code5;
  } report_t;

  typedef struct packed {
    cmd_t                  cmd;
    logic [CODE_W-1:0]     key_modifier;
    logic [CODE_W-1:0]     key_code0;
    logic [CODE_W-1:0]     key_code1;
    logic [CODE_W-1:0]     key_code2;
    logic [CODE_W-1:0]     key_code3;
    logic [CODE_W-1:0]     key_code4;
    logic [CODE_W-1:0]     key_code5;
    logic [OWNER_W-1:0]    owner_id;
    logic [SLOT_NUM_W-1:0] shortcut_slot;
  } in_item_t;

  typedef struct packed {
    status_t               status;
    logic                  overwrote_oldest;
    logic [CODE_W-1:0]     out_modifier;
    logic [CODE_W-1:0]     out_code0;
    logic [CODE_W-1:0]     out_code1;
    logic [CODE_W-1:0]     out_code2;
    logic [CODE_W-1:0]     out_code3;
    logic [CODE_W-1:0]     out_code4;
    logic [CODE_W-1:0]     out_code5;
    logic [SLOT_NUM_W-1:0] new_slot;
  } out_item_t;

  function automatic report_t pack_report(input in_item_t it);
    report_t r;
    r.modifier = it.key_modifier;
    r.code0    = it.key_code0;
    r.code1    = it.key_code1;
    r.code2    = it.key_code2;
    r.code3    = it.key_code3;
    r.code4    = it.key_code4;
    r.code5    = it.key_code5;
    return r;
  endfunction

endpackage

FILE: rtl/core/hkf_if.sv
// interfaces: command, result and configuration channels
`timescale 1ns / 1ps
interface hkf_req_if;
  logic             valid;
  logic             ready;
  hkf_pkg::in_item_t data;
  modport source (output valid, output data, input ready);
  modport sink (input valid, input data, output ready);
endinterface

interface hkf_rsp_if;
  logic               valid;
  logic               ready;
  hkf_pkg::out_item_t data;
  modport source (output valid, output data, input ready);
  modport sink (input valid, input data, output ready);
endinterface

interface hkf_cfg_if;
  logic              valid;
  logic              ready;
  hkf_pkg::cfg_idx_t index;
  logic              data;
  modport source (output valid, output index, output data, input ready);
  modport sink (input valid, input index, input data, output ready);
endinterface

FILE: rtl/core/hkf_ram.sv
// generic single-write, single-read ram with registered read data
`timescale 1ns / 1ps
module hkf_ram #(
  parameter int WIDTH  = 8,
  parameter int DEPTH  = 16,
  parameter int ADDR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
  input  logic              clk,
  input  logic              we,
  input  logic [ADDR_W-1:0] waddr,
  input  logic [WIDTH-1:0]  wdata,
  input  logic              re,
  input  logic [ADDR_W-1:0] raddr,
  output logic [WIDTH-1:0]  rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (re) begin
      rdata <= mem[raddr];
    end
  end

endmodule

FILE: rtl/core/hkf_seq.sv
// command sequencer: slot scan, ring pointers, subscribe and query handling
`timescale 1ns / 1ps
module hkf_seq #(
  parameter int RING_DEPTH = hkf_pkg::RING_DEPTH_DEF,
  parameter int SLOT_COUNT = hkf_pkg::SLOT_COUNT_DEF,
  parameter int RP_W       = $clog2(RING_DEPTH),
  parameter int SLOT_W     = (SLOT_COUNT > 1) ? $clog2(SLOT_COUNT) : 1
) (
  input  logic                           clk,
  input  logic                           rst,
  input  logic                           shortcut_bypass,
  input  logic                           focus_valid,
  input  logic                           in_valid,
  output logic                           in_ready,
  input  hkf_pkg::in_item_t              in_data,
  output logic                           res_valid,
  input  logic                           res_take,
  output hkf_pkg::out_item_t             res_data,
  output logic                           tbl_we,
  output logic                           tbl_re,
  output logic [SLOT_W-1:0]              tbl_addr,
  output logic [hkf_pkg::TABLE_W-1:0]    tbl_wdata,
  input  logic [hkf_pkg::TABLE_W-1:0]    tbl_rdata,
  output logic                           ring_we,
  output logic [RP_W-1:0]                ring_waddr,
  output logic [hkf_pkg::REPORT_W-1:0]   ring_wdata,
  output logic                           ring_re,
  output logic [RP_W-1:0]                ring_raddr,
  input  logic [hkf_pkg::REPORT_W-1:0]   ring_rdata
);

  localparam int USED_W = $clog2(SLOT_COUNT + 1);

  hkf_pkg::state_t    state, state_next;
  logic [RP_W-1:0]    wp, wp_next;
  logic [RP_W-1:0]    rp, rp_next;
  logic [USED_W-1:0]  slots_used, slots_used_next;
  logic [SLOT_COUNT-1:0] flags, flags_next;
  logic [USED_W-1:0]  scan_idx, scan_idx_next;
  logic               cmp_vld, cmp_vld_next;
  logic [SLOT_W-1:0]  cmp_idx, cmp_idx_next;
  hkf_pkg::in_item_t  item, item_next;
  hkf_pkg::out_item_t res, res_next;

  hkf_pkg::report_t   pop_rep;
  hkf_pkg::report_t   tbl_rep;
  logic [hkf_pkg::OWNER_W-1:0] tbl_owner;
  logic               match;
  logic               issue;
  logic               table_full;
  logic [RP_W-1:0]    wp_inc;
  logic [SLOT_W-1:0]  query_idx;

  function automatic logic [RP_W-1:0] ring_inc(input logic [RP_W-1:0] p);
    return (p == RP_W'(RING_DEPTH - 1)) ? '0 : p + 1'b1;
  endfunction

  assign pop_rep    = ring_rdata;
  assign tbl_rep    = tbl_rdata[hkf_pkg::TABLE_W-1:hkf_pkg::OWNER_W];
  assign tbl_owner  = tbl_rdata[hkf_pkg::OWNER_W-1:0];
  assign match      = (tbl_rep == hkf_pkg::pack_report(item));
  assign issue      = (scan_idx < slots_used);
  assign table_full = (slots_used == USED_W'(SLOT_COUNT));
  assign wp_inc     = ring_inc(wp);
  assign query_idx  = SLOT_W'(item.shortcut_slot);
  assign res_valid  = (state == hkf_pkg::S_RESULT);
  assign res_data   = res;

  always_ff @(posedge clk) begin
    if (rst) begin
      state      <= hkf_pkg::S_IDLE;
      wp         <= '0;
      rp         <= '0;
      slots_used <= '0;
      flags      <= '0;
      cmp_vld    <= 1'b0;
    end else begin
      state      <= state_next;
      wp         <= wp_next;
      rp         <= rp_next;
      slots_used <= slots_used_next;
      flags      <= flags_next;
      cmp_vld    <= cmp_vld_next;
    end
  end

  always_ff @(posedge clk) begin
    item     <= item_next;
    res      <= res_next;
    scan_idx <= scan_idx_next;
    cmp_idx  <= cmp_idx_next;
  end

  always_comb begin
    state_next      = state;
    wp_next         = wp;
    rp_next         = rp;
    slots_used_next = slots_used;
    flags_next      = flags;
    scan_idx_next   = scan_idx;
    cmp_vld_next    = 1'b0;
    cmp_idx_next    = cmp_idx;
    item_next       = item;
    res_next        = res;
    in_ready        = 1'b0;
    tbl_we          = 1'b0;
    tbl_re          = 1'b0;
    tbl_addr        = scan_idx[SLOT_W-1:0];
    tbl_wdata       = {hkf_pkg::pack_report(in_data), in_data.owner_id};
    ring_we         = 1'b0;
    ring_waddr      = wp;
    ring_wdata      = hkf_pkg::pack_report(item);
    ring_re         = 1'b0;
    ring_raddr      = rp;

    unique case (state)
      hkf_pkg::S_IDLE: begin
        in_ready = 1'b1;
        if (in_valid) begin
          item_next = in_data;
          res_next  = '0;
          unique case (in_data.cmd)
            hkf_pkg::CMD_KEYPRESS: begin
              if (!shortcut_bypass && (slots_used != '0)) begin
                scan_idx_next = '0;
                state_next    = hkf_pkg::S_SCAN;
              end else begin
                state_next = hkf_pkg::S_ENQUEUE;
              end
            end
            hkf_pkg::CMD_READ: begin
              if (rp == wp) begin
                res_next.status = hkf_pkg::ST_EMPTY;
                state_next      = hkf_pkg::S_RESULT;
              end else begin
                ring_re    = 1'b1;
                state_next = hkf_pkg::S_POP_WAIT;
              end
            end
            hkf_pkg::CMD_SUBSCRIBE: begin
              if (table_full) begin
                res_next.status = hkf_pkg::ST_FULL;
              end else begin
                tbl_we                            = 1'b1;
                tbl_addr                          = slots_used[SLOT_W-1:0];
                flags_next[slots_used[SLOT_W-1:0]] = 1'b0;
                res_next.new_slot                 = hkf_pkg::SLOT_NUM_W'(slots_used);
                slots_used_next                   = slots_used + 1'b1;
              end
              state_next = hkf_pkg::S_RESULT;
            end
            hkf_pkg::CMD_QUERY: begin
              if (int'(in_data.shortcut_slot) < SLOT_COUNT) begin
                tbl_re     = 1'b1;
                tbl_addr   = SLOT_W'(in_data.shortcut_slot);
                state_next = hkf_pkg::S_QUERY_WAIT;
              end else begin
                res_next.status = hkf_pkg::ST_EMPTY;
                state_next      = hkf_pkg::S_RESULT;
              end
            end
          endcase
        end
      end

      // one read issued per cycle, each compared in the cycle after its read
      hkf_pkg::S_SCAN: begin
        if (cmp_vld && match) begin
          flags_next[cmp_idx] = 1'b1;
          res_next.status     = hkf_pkg::ST_ABSORBED;
          state_next          = hkf_pkg::S_RESULT;
        end else if (issue) begin
          tbl_re        = 1'b1;
          scan_idx_next = scan_idx + 1'b1;
          cmp_vld_next  = 1'b1;
          cmp_idx_next  = scan_idx[SLOT_W-1:0];
        end else begin
          state_next = hkf_pkg::S_ENQUEUE;
        end
      end

      hkf_pkg::S_ENQUEUE: begin
        if (!focus_valid) begin
          res_next.status = hkf_pkg::ST_NOFOCUS;
        end else begin
          ring_we = 1'b1;
          wp_next = wp_inc;
          if (wp_inc == rp) begin
            rp_next                   = ring_inc(rp);
            res_next.overwrote_oldest = 1'b1;
          end
        end
        state_next = hkf_pkg::S_RESULT;
      end

      hkf_pkg::S_POP_WAIT: begin
        rp_next               = ring_inc(rp);
        res_next.out_modifier = pop_rep.modifier;
        res_next.out_code0    = pop_rep.code0;
        res_next.out_code1    = pop_rep.code1;
        res_next.out_code2    = pop_rep.code2;
        res_next.out_code3    = pop_rep.code3;
        res_next.out_code4    = pop_rep.code4;
        res_next.out_code5    = pop_rep.code5;
        state_next            = hkf_pkg::S_RESULT;
      end

      hkf_pkg::S_QUERY_WAIT: begin
        if (flags[query_idx] && (tbl_owner == item.owner_id)) begin
          flags_next[query_idx] = 1'b0;
          res_next.status       = hkf_pkg::ST_OK;
        end else begin
          res_next.status = hkf_pkg::ST_EMPTY;
        end
        state_next = hkf_pkg::S_RESULT;
      end

      hkf_pkg::S_RESULT: begin
        if (res_take) begin
          state_next = hkf_pkg::S_IDLE;
        end
      end

      default: begin
        state_next = hkf_pkg::S_IDLE;
      end
    endcase
  end

endmodule

FILE: rtl/core/hotkey_filter_with_key_fifo.sv
// top level: hotkey filter with shortcut table and report ring buffer
//
//   channel | dir | handshake          | payload
//   --------+-----+--------------------+-------------------------------------------
//   req     | in  | req.valid/ready    | cmd, report, owner_id, shortcut_slot
//   rsp     | out | rsp.valid/ready    | status, overwrote_oldest, report, new_slot
//   cfg     | in  | cfg.valid/ready    | index (shortcut_bypass, focus_valid), data
//
// one command is in work at a time; its steps from accept to the next accept:
//   keypress: slot scan when scanned, enqueue unless a slot matched, result
//   read, query: ram read, wait, result (just result: empty ring or slot past table)
//   subscribe: table write, result
// the slot scan reads one table entry per cycle, so slots_used sets keypress time
// rst clears pointers, slot count, triggered flags and the result stage; the rams
// are not cleared. a finished result sits in the output register, and the next
// command is accepted while it waits; a stalled rsp holds the sequencer in its
// result step only when a second result is ready behind it
`timescale 1ns / 1ps
module hotkey_filter_with_key_fifo #(
  parameter int RING_DEPTH = hkf_pkg::RING_DEPTH_DEF,
  parameter int SLOT_COUNT = hkf_pkg::SLOT_COUNT_DEF
) (
  input  logic      clk,
  input  logic      rst,
  hkf_req_if.sink   req,
  hkf_rsp_if.source rsp,
  hkf_cfg_if.sink   cfg
);

  localparam int RP_W   = $clog2(RING_DEPTH);
  localparam int SLOT_W = (SLOT_COUNT > 1) ? $clog2(SLOT_COUNT) : 1;

  // configuration registers
  logic shortcut_bypass;
  logic focus_valid;

  // output stage
  logic               out_valid;
  hkf_pkg::out_item_t out_data;
  logic               res_valid;
  logic               res_take;
  hkf_pkg::out_item_t res_data;

  // shortcut table ram: {pattern, owner}
  logic                        tbl_we;
  logic                        tbl_re;
  logic [SLOT_W-1:0]           tbl_addr;
  logic [hkf_pkg::TABLE_W-1:0] tbl_wdata;
  logic [hkf_pkg::TABLE_W-1:0] tbl_rdata;

  // report ring ram
  logic                         ring_we;
  logic [RP_W-1:0]              ring_waddr;
  logic [hkf_pkg::REPORT_W-1:0] ring_wdata;
  logic                         ring_re;
  logic [RP_W-1:0]              ring_raddr;
  logic [hkf_pkg::REPORT_W-1:0] ring_rdata;

  // config writes land at once, always ready
  assign cfg.ready = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      shortcut_bypass <= 1'b0;
      focus_valid     <= 1'b0;
    end else if (cfg.valid) begin
      unique case (cfg.index)
        hkf_pkg::CFG_SHORTCUT_BYPASS: shortcut_bypass <= cfg.data;
        hkf_pkg::CFG_FOCUS_VALID:     focus_valid     <= cfg.data;
      endcase
    end
  end

  // result register between sequencer and rsp
  assign res_take  = !out_valid || rsp.ready;
  assign rsp.valid = out_valid;
  assign rsp.data  = out_data;

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (res_valid && res_take) begin
      out_valid <= 1'b1;
    end else if (rsp.ready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (res_valid && res_take) begin
      out_data <= res_data;
    end
  end

  hkf_seq #(
    .RING_DEPTH (RING_DEPTH),
    .SLOT_COUNT (SLOT_COUNT),
    .RP_W       (RP_W),
    .SLOT_W     (SLOT_W)
  ) u_seq (
    .clk             (clk),
    .rst             (rst),
    .shortcut_bypass (shortcut_bypass),
    .focus_valid     (focus_valid),
    .in_valid        (req.valid),
    .in_ready        (req.ready),
    .in_data         (req.data),
    .res_valid       (res_valid),
    .res_take        (res_take),
    .res_data        (res_data),
    .tbl_we          (tbl_we),
    .tbl_re          (tbl_re),
    .tbl_addr        (tbl_addr),
    .tbl_wdata       (tbl_wdata),
    .tbl_rdata       (tbl_rdata),
    .ring_we         (ring_we),
    .ring_waddr      (ring_waddr),
    .ring_wdata      (ring_wdata),
    .ring_re         (ring_re),
    .ring_raddr      (ring_raddr),
    .ring_rdata      (ring_rdata)
  );

  // table ram is single address: one write or one read per cycle
  hkf_ram #(
    .WIDTH  (hkf_pkg::TABLE_W),
    .DEPTH  (SLOT_COUNT),
    .ADDR_W (SLOT_W)
  ) u_tbl_ram (
    .clk   (clk),
    .we    (tbl_we),
    .waddr (tbl_addr),
    .wdata (tbl_wdata),
    .re    (tbl_re),
    .raddr (tbl_addr),
    .rdata (tbl_rdata)
  );

  hkf_ram #(
    .WIDTH  (hkf_pkg::REPORT_W),
    .DEPTH  (RING_DEPTH),
    .ADDR_W (RP_W)
  ) u_ring_ram (
    .clk   (clk),
    .we    (ring_we),
    .waddr (ring_waddr),
    .wdata (ring_wdata),
    .re    (ring_re),
    .raddr (ring_raddr),
    .rdata (ring_rdata)
  );

endmodule

FILE: rtl/core/hkf_checker.sv
// checker on the top level ports, bound to the top level
`timescale 1ns / 1ps
module hkf_checker (
  input logic               clk,
  input logic               rst,
  input logic               req_valid,
  input logic               req_ready,
  input logic               rsp_valid,
  input logic               rsp_ready,
  input hkf_pkg::out_item_t rsp_data
);

  // result stage empties on reset
  a_rst_clears: assert property (@(posedge clk) rst |=> !rsp_valid)
    else $error("result valid after reset");

  // stalled result holds
  a_rsp_hold: assert property (@(posedge clk) disable iff (rst)
    rsp_valid && !rsp_ready |=> rsp_valid && $stable(rsp_data))
    else $error("stalled result changed");

  // one command in work at a time
  a_one_in_work: assert property (@(posedge clk) disable iff (rst)
    req_valid && req_ready |=> !req_ready)
    else $error("command accepted while another is in work");

  // overwrite only flagged on a queued keypress
  a_overwrite_ok: assert property (@(posedge clk) disable iff (rst)
    rsp_valid && rsp_data.overwrote_oldest |-> rsp_data.status == hkf_pkg::ST_OK)
    else $error("overwrite flag with non-ok status");

  // failed commands carry no report or slot
  a_fail_zero: assert property (@(posedge clk) disable iff (rst)
    rsp_valid && (rsp_data.status != hkf_pkg::ST_OK) |->
      (rsp_data.out_modifier == '0) && (rsp_data.out_code0 == '0) &&
      (rsp_data.out_code5 == '0) && (rsp_data.new_slot == '0))
    else $error("non-ok result carries data");

endmodule

bind hotkey_filter_with_key_fifo hkf_checker u_checker (
  .clk       (clk),
  .rst       (rst),
  .req_valid (req.valid),
  .req_ready (req.ready),
  .rsp_valid (rsp.valid),
  .rsp_ready (rsp.ready),
  .rsp_data  (rsp.data)
);

FILE: sim/hotkey_filter_with_key_fifo_tb.sv
// testbench: hotkey filter with key fifo, random and directed commands checked by a shadow model
`timescale 1ns / 1ps
module hotkey_filter_with_key_fifo_tb;

  // shadow copy of the block: shortcut table, triggered flags, report ring and
  // the two mode bits, plus the queue of results still owed by the block
  class hotkey_scoreboard;
    hkf_pkg::report_t   patterns [hkf_pkg::SLOT_COUNT_DEF];
    logic [15:0]        owners   [hkf_pkg::SLOT_COUNT_DEF];
    bit                 flags    [hkf_pkg::SLOT_COUNT_DEF];
    int                 slots_used;
    hkf_pkg::report_t   ring     [hkf_pkg::RING_DEPTH_DEF];
    int                 wr_ptr;
    int                 rd_ptr;
    bit                 shortcut_bypass;
    bit                 focus_valid;
    hkf_pkg::out_item_t expected_results [$];
    int                 errors;

    function new();
      foreach (flags[i]) flags[i] = 1'b0;
      slots_used      = 0;
      wr_ptr          = 0;
      rd_ptr          = 0;
      shortcut_bypass = 1'b0;
      focus_valid     = 1'b0;
      errors          = 0;
    endfunction

    function void set_config(hkf_pkg::cfg_idx_t idx, logic val);
      if (idx == hkf_pkg::CFG_SHORTCUT_BYPASS) shortcut_bypass = val;
      else focus_valid = val;
    endfunction

    function int pending();
      return expected_results.size();
    endfunction

    // works out the result of one accepted command and updates the shadow state
    function void note_command(hkf_pkg::in_item_t c);
      hkf_pkg::out_item_t r;
      hkf_pkg::report_t   rep;
      bit                 hit;
      r   = '0;
      hit = 1'b0;
      rep = {c.key_modifier, c.key_code0, c.key_code1, c.key_code2,
             c.key_code3, c.key_code4, c.key_code5};
      case (c.cmd)
        hkf_pkg::CMD_KEYPRESS: begin
          // first matching slot wins, unless the bypass skips the scan
          if (!shortcut_bypass)
            for (int i = 0; i < slots_used && !hit; i++)
              if (patterns[i] == rep) begin
                flags[i] = 1'b1;
                hit      = 1'b1;
              end
          if (hit) r.status = hkf_pkg::ST_ABSORBED;
          else if (!focus_valid) r.status = hkf_pkg::ST_NOFOCUS;
          else begin
            ring[wr_ptr] = rep;
            wr_ptr = (wr_ptr + 1) % hkf_pkg::RING_DEPTH_DEF;
            // ring keeps one entry free: catching up drops the oldest report
            if (wr_ptr == rd_ptr) begin
              rd_ptr = (rd_ptr + 1) % hkf_pkg::RING_DEPTH_DEF;
              r.overwrote_oldest = 1'b1;
            end
            r.status = hkf_pkg::ST_OK;
          end
        end
        hkf_pkg::CMD_READ: begin
          if (rd_ptr == wr_ptr) r.status = hkf_pkg::ST_EMPTY;
          else begin
            {r.out_modifier, r.out_code0, r.out_code1, r.out_code2,
             r.out_code3, r.out_code4, r.out_code5} = ring[rd_ptr];
            rd_ptr   = (rd_ptr + 1) % hkf_pkg::RING_DEPTH_DEF;
            r.status = hkf_pkg::ST_OK;
          end
        end
        hkf_pkg::CMD_SUBSCRIBE: begin
          if (slots_used >= hkf_pkg::SLOT_COUNT_DEF) r.status = hkf_pkg::ST_FULL;
          else begin
            patterns[slots_used] = rep;
            owners[slots_used]   = c.owner_id;
            flags[slots_used]    = 1'b0;
            r.new_slot           = hkf_pkg::SLOT_NUM_W'(slots_used);
            r.status             = hkf_pkg::ST_OK;
            slots_used++;
          end
        end
        default: begin
          // only the owner may read and clear a triggered flag
          if (flags[c.shortcut_slot] && owners[c.shortcut_slot] == c.owner_id) begin
            flags[c.shortcut_slot] = 1'b0;
            r.status = hkf_pkg::ST_OK;
          end else begin
            r.status = hkf_pkg::ST_EMPTY;
          end
        end
      endcase
      expected_results.push_back(r);
    endfunction

    function void check_result(hkf_pkg::out_item_t got);
      hkf_pkg::out_item_t want;
      if (expected_results.size() == 0) begin
        errors++;
        $display("%0t ns: unexpected result, status %0h", $time, got.status);
        return;
      end
      want = expected_results.pop_front();
      // status, overwrote_oldest, report bytes, new_slot packed in that order
      if (want !== got) begin
        errors++;
        $display("%0t ns: result expected %h, actual %h", $time, want, got);
      end
    endfunction
  endclass

  // receiver stall patterns, switched in random segments
  typedef enum int {
    RX_ALWAYS,
    RX_COIN,
    RX_EVERY_THIRD,
    RX_SPARSE
  } rx_mode_t;

  logic clk = 1'b0;
  logic rst;

  hkf_req_if req_ch ();
  hkf_rsp_if rsp_ch ();
  hkf_cfg_if cfg_ch ();

  hotkey_filter_with_key_fifo DUT (
    .clk (clk),
    .rst (rst),
    .req (req_ch),
    .rsp (rsp_ch),
    .cfg (cfg_ch)
  );

  hotkey_scoreboard sb = new();

  // sender burst bookkeeping
  int burst_left = 0;
  // long receiver hold-off, requested by the stimulus and counted down by the receiver
  int rx_hold_cycles = 0;

  // 12 ns clock
  always begin
    #6 clk = 1'b1;
    #6 clk = 1'b0;
  end

  // run limit, far above the slowest legal run
  initial begin
    #5_000_000;
    $display("hotkey_filter_with_key_fifo: mismatch");
    $finish;
  end

  // monitor: sample both handshakes at the rising edge
  always @(posedge clk) begin
    if (!rst) begin
      if (rsp_ch.valid && rsp_ch.ready) sb.check_result(rsp_ch.data);
      if (req_ch.valid && req_ch.ready) sb.note_command(req_ch.data);
    end
  end

  // receiver: ready changes on the falling edge, random segments of stall patterns,
  // with a long hold-off whenever one is requested
  initial begin
    rx_mode_t rx_mode;
    int       seg_left;
    int       phase_cnt;
    rx_mode   = RX_ALWAYS;
    seg_left  = 0;
    phase_cnt = 0;
    rsp_ch.ready = 1'b0;
    forever begin
      @(negedge clk);
      phase_cnt++;
      if (rx_hold_cycles > 0) begin
        rx_hold_cycles--;
        rsp_ch.ready <= 1'b0;
      end else begin
        if (seg_left == 0) begin
          seg_left = $urandom_range(16, 96);
          rx_mode  = rx_mode_t'($urandom_range(0, 3));
        end
        seg_left--;
        case (rx_mode)
          RX_ALWAYS:      rsp_ch.ready <= 1'b1;
          RX_COIN:        rsp_ch.ready <= 1'($urandom_range(0, 1));
          RX_EVERY_THIRD: rsp_ch.ready <= (phase_cnt % 3) != 0;
          default:        rsp_ch.ready <= ($urandom_range(0, 7) == 0);
        endcase
      end
    end
  end

  // key byte with a bias toward the extremes
  function automatic logic [7:0] rand_key_byte();
    case ($urandom_range(0, 7))
      0:       return 8'h00;
      1:       return 8'hFF;
      default: return 8'($urandom_range(0, 255));
    endcase
  endfunction

  function automatic hkf_pkg::in_item_t mk_cmd(hkf_pkg::cmd_t op, hkf_pkg::report_t rep,
                                               logic [15:0] owner, logic [3:0] slot);
    hkf_pkg::in_item_t c;
    c.cmd = op;
    {c.key_modifier, c.key_code0, c.key_code1, c.key_code2,
     c.key_code3, c.key_code4, c.key_code5} = rep;
    c.owner_id      = owner;
    c.shortcut_slot = slot;
    return c;
  endfunction

  // random command; keypresses often replay a subscribed shortcut or a near miss,
  // queries often name a used slot with its real owner
  function automatic hkf_pkg::in_item_t random_command(int w_key, int w_read, int w_sub);
    hkf_pkg::report_t rep;
    logic [15:0]      owner;
    logic [3:0]       slot;
    int               pick;
    int               s;
    rep = {rand_key_byte(), rand_key_byte(), rand_key_byte(), rand_key_byte(),
           rand_key_byte(), rand_key_byte(), rand_key_byte()};
    case ($urandom_range(0, 9))
      0:       owner = 16'h0000;
      1:       owner = 16'hFFFF;
      default: owner = 16'($urandom_range(0, 65535));
    endcase
    slot = 4'($urandom_range(0, 15));
    pick = $urandom_range(0, 99);
    if (pick < w_key) begin
      if (sb.slots_used > 0 && $urandom_range(0, 99) < 45) begin
        s   = $urandom_range(0, sb.slots_used - 1);
        rep = sb.patterns[s];
        // one flipped bit: must miss this slot
        if ($urandom_range(0, 3) == 0)
          rep = rep ^ (56'd1 << $urandom_range(0, hkf_pkg::REPORT_W - 1));
      end
      return mk_cmd(hkf_pkg::CMD_KEYPRESS, rep, owner, slot);
    end
    if (pick < w_key + w_read) return mk_cmd(hkf_pkg::CMD_READ, rep, owner, slot);
    if (pick < w_key + w_read + w_sub) begin
      // duplicate patterns check the slot-order priority
      if (sb.slots_used > 0 && $urandom_range(0, 3) == 0)
        rep = sb.patterns[$urandom_range(0, sb.slots_used - 1)];
      return mk_cmd(hkf_pkg::CMD_SUBSCRIBE, rep, owner, slot);
    end
    if (sb.slots_used > 0 && $urandom_range(0, 2) != 0) begin
      s    = $urandom_range(0, sb.slots_used - 1);
      slot = 4'(s);
      if ($urandom_range(0, 3) != 0) owner = sb.owners[s];
    end
    return mk_cmd(hkf_pkg::CMD_QUERY, rep, owner, slot);
  endfunction

  // sender: bursts of random length, random gaps between them, valid held across a burst
  task automatic send_command(hkf_pkg::in_item_t c);
    int idle;
    if (burst_left == 0) begin
      burst_left = $urandom_range(1, 16);
      idle = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 8);
      if (idle != 0) begin
        @(negedge clk);
        req_ch.valid <= 1'b0;
        repeat (idle - 1) @(negedge clk);
      end
    end
    burst_left--;
    @(negedge clk);
    req_ch.valid <= 1'b1;
    req_ch.data  <= c;
    do @(posedge clk); while (!req_ch.ready);
  endtask

  // drop valid and wait until every owed result has come back
  task automatic wait_drained();
    @(negedge clk);
    req_ch.valid <= 1'b0;
    burst_left = 0;
    while (sb.pending() != 0) @(posedge clk);
  endtask

  // register write; only called while the block is idle
  task automatic write_cfg(hkf_pkg::cfg_idx_t idx, logic val);
    @(negedge clk);
    cfg_ch.valid <= 1'b1;
    cfg_ch.index <= idx;
    cfg_ch.data  <= val;
    do @(posedge clk); while (!cfg_ch.ready);
    sb.set_config(idx, val);
    @(negedge clk);
    cfg_ch.valid <= 1'b0;
  endtask

  // one random phase under a fixed mode setting
  task automatic run_phase(logic bypass, logic focus, int count, int w_key, int w_read,
                           int w_sub, int hold, bit pause_midway);
    wait_drained();
    write_cfg(hkf_pkg::CFG_SHORTCUT_BYPASS, bypass);
    write_cfg(hkf_pkg::CFG_FOCUS_VALID, focus);
    // long receiver hold-off while commands keep coming: block fills and stalls req
    rx_hold_cycles = hold;
    for (int n = 0; n < count; n++) begin
      if (pause_midway && n == count / 2) wait_drained();
      send_command(random_command(w_key, w_read, w_sub));
    end
  endtask

  // main stimulus
  initial begin
    hkf_pkg::report_t pat_a;
    hkf_pkg::report_t pat_b;
    hkf_pkg::report_t all_ones;
    pat_a    = {8'hFF, 8'h00, 8'h04, 8'h05, 8'h06, 8'h07, 8'hFF};
    pat_b    = {8'h01, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00, 8'h80};
    all_ones = '1;

    rst = 1'b1;
    req_ch.valid = 1'b0;
    req_ch.data  = '0;
    cfg_ch.valid = 1'b0;
    cfg_ch.index = hkf_pkg::CFG_SHORTCUT_BYPASS;
    cfg_ch.data  = 1'b0;
    repeat (10) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;

    // directed: no focus, shortcut matching on
    write_cfg(hkf_pkg::CFG_SHORTCUT_BYPASS, 1'b0);
    write_cfg(hkf_pkg::CFG_FOCUS_VALID, 1'b0);
    send_command(mk_cmd(hkf_pkg::CMD_READ, '0, 16'h0000, 4'd0));     // read on empty ring
    send_command(mk_cmd(hkf_pkg::CMD_QUERY, '0, 16'h0000, 4'd0));    // query of an unused slot
    send_command(mk_cmd(hkf_pkg::CMD_QUERY, all_ones, 16'hFFFF, 4'd15));
    send_command(mk_cmd(hkf_pkg::CMD_KEYPRESS, '0, 16'h0000, 4'd0)); // dropped, no focus
    send_command(mk_cmd(hkf_pkg::CMD_KEYPRESS, all_ones, 16'hFFFF, 4'd15));
    send_command(mk_cmd(hkf_pkg::CMD_SUBSCRIBE, pat_a, 16'hFFFF, 4'd0)); // slot 0
    send_command(mk_cmd(hkf_pkg::CMD_SUBSCRIBE, pat_b, 16'h0000, 4'd0)); // slot 1
    send_command(mk_cmd(hkf_pkg::CMD_SUBSCRIBE, pat_a, 16'h1234, 4'd0)); // duplicate, slot 2
    send_command(mk_cmd(hkf_pkg::CMD_KEYPRESS, pat_a, 16'h0000, 4'd0));  // absorbed by slot 0
    send_command(mk_cmd(hkf_pkg::CMD_KEYPRESS, pat_b, 16'h0000, 4'd0));  // absorbed by slot 1
    send_command(mk_cmd(hkf_pkg::CMD_QUERY, '0, 16'h0000, 4'd0));        // wrong owner
    send_command(mk_cmd(hkf_pkg::CMD_QUERY, '0, 16'hFFFF, 4'd0));        // owner, flag set
    send_command(mk_cmd(hkf_pkg::CMD_QUERY, '0, 16'hFFFF, 4'd0));        // flag now clear
    send_command(mk_cmd(hkf_pkg::CMD_QUERY, '0, 16'h1234, 4'd2));        // duplicate never hit
    send_command(mk_cmd(hkf_pkg::CMD_KEYPRESS, pat_a ^ 56'h1, 16'h0000, 4'd0)); // near miss

    // directed: shortcut bypass with focus, everything queues
    wait_drained();
    write_cfg(hkf_pkg::CFG_SHORTCUT_BYPASS, 1'b1);
    write_cfg(hkf_pkg::CFG_FOCUS_VALID, 1'b1);
    send_command(mk_cmd(hkf_pkg::CMD_KEYPRESS, pat_a, 16'h0000, 4'd0));
    send_command(mk_cmd(hkf_pkg::CMD_KEYPRESS, all_ones, 16'h0000, 4'd0));
    send_command(mk_cmd(hkf_pkg::CMD_READ, '0, 16'h0000, 4'd0));
    send_command(mk_cmd(hkf_pkg::CMD_READ, '0, 16'h0000, 4'd0));
    send_command(mk_cmd(hkf_pkg::CMD_READ, '0, 16'h0000, 4'd0));       // empty again
    send_command(mk_cmd(hkf_pkg::CMD_QUERY, '0, 16'h0000, 4'd1));      // slot 1 was triggered
    send_command(mk_cmd(hkf_pkg::CMD_QUERY, '0, 16'h0000, 4'd1));

    // random phases over all mode settings; table fills in the first one,
    // the keypress-heavy bypass phase wraps the ring and takes the long hold-off,
    // one phase pauses halfway until all results are back
    run_phase(1'b0, 1'b1, 150, 45, 15, 15, 0,   1'b0);
    run_phase(1'b1, 1'b1, 130, 85, 5,  5,  300, 1'b0);
    run_phase(1'b0, 1'b0, 80,  40, 30, 10, 0,   1'b0);
    run_phase(1'b0, 1'b1, 100, 50, 25, 5,  0,   1'b1);
    run_phase(1'b1, 1'b0, 100, 30, 45, 5,  0,   1'b0);
    run_phase(1'b0, 1'b1, 90,  50, 25, 5,  0,   1'b0);

    wait_drained();
    // keep the clock running to catch any stray result
    repeat (40) @(posedge clk);
    if (sb.errors == 0 && sb.pending() == 0) begin
      $display("hotkey_filter_with_key_fifo: match");
    end else begin
      $display("hotkey_filter_with_key_fifo: mismatch");
    end
    $finish;
  end

endmodule
